// File: rtl/core/day_number_to_date_defines.svh
`ifndef DAY_NUMBER_TO_DATE_DEFINES_SVH
`define DAY_NUMBER_TO_DATE_DEFINES_SVH

// assertion macros for the day number to date block

`ifndef NO_ASSERTIONS

// consequent must hold in the same cycle as the antecedent
`define DNTD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("day_number_to_date check failed");

// consequent must hold in the cycle after the antecedent
`define DNTD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("day_number_to_date check failed");

`else

`define DNTD_ASSERT_NOW(label, ante, cons)
`define DNTD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: rtl/core/dntd_pkg.sv
`default_nettype none

package dntd_pkg;

  // widths of the working registers
  localparam int REM_W  = 17;  // day remainder, up to 73048
  localparam int YOFF_W = 8;   // years past 1900, up to 199

  localparam logic [11:0]       FIRST_YEAR = 12'd1900;
  localparam logic signed [31:0] FIRST_DAY = 32'sd1;
  localparam logic signed [31:0] LAST_DAY  = 32'sd73049;
  localparam logic [REM_W-1:0]  MAX_REM    = 17'd73048;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic [8:0] DAYS_LEAP_YEAR   = 9'd366;
  localparam logic [8:0] DAYS_COMMON_YEAR = 9'd365;
  localparam logic [4:0] DAYS_LEAP_FEB    = 5'd29;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // datapath commands
  typedef struct packed {
    logic load;
    logic year_step;
    logic month_step;
    logic capture;
  } dntd_cmd_t;

  // datapath status
  typedef struct packed {
    logic rem_lt_year;
    logic rem_lt_month;
    logic month_last;
  } dntd_sts_t;

  // within 1900..2099 a year is leap when divisible by 4, except 1900;
  // 2000 is divisible by 400 and stays leap
  function automatic logic is_leap(input logic [YOFF_W-1:0] yoff);
    return (yoff[1:0] == 2'b00) && (yoff != '0);
  endfunction

  function automatic logic [8:0] year_len(input logic [YOFF_W-1:0] yoff);
    return is_leap(yoff) ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [3:0] idx;
    idx = month - MONTH_JAN;
    if (month == MONTH_FEB && leap) begin
      return DAYS_LEAP_FEB;
    end
    return MONTH_LEN[idx];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/dntd_dpath.sv
`default_nettype none

module dntd_dpath (
  input  wire logic                clk,
  input  wire logic signed [31:0]  day_number,
  input  wire dntd_pkg::dntd_cmd_t cmd,
  output dntd_pkg::dntd_sts_t      sts,
  output logic [11:0]              year_out,
  output logic [3:0]               month_out,
  output logic [4:0]               day_out
);
  import dntd_pkg::*;

  logic [REM_W-1:0]  rem;
  logic [YOFF_W-1:0] yoff;
  logic [3:0]        month;

  logic [REM_W-1:0]  rem_start;
  logic signed [31:0] day_m1;
  logic [8:0]        ylen;
  logic [4:0]        mlen;

  // clamp the incoming day number to the covered span, zero based
  always_comb begin
    day_m1 = day_number - FIRST_DAY;
    if (day_number < FIRST_DAY) begin
      rem_start = '0;
    end else if (day_number > LAST_DAY) begin
      rem_start = MAX_REM;
    end else begin
      rem_start = day_m1[REM_W-1:0];
    end
  end

  // lengths of the current year and month
  assign ylen = year_len(yoff);
  assign mlen = month_len(month, is_leap(yoff));

  assign sts.rem_lt_year  = rem < {{(REM_W-9){1'b0}}, ylen};
  assign sts.rem_lt_month = rem < {{(REM_W-5){1'b0}}, mlen};
  assign sts.month_last   = month == MONTH_DEC;

  // remainder, year and month registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem   <= rem_start;
      yoff  <= '0;
      month <= MONTH_JAN;
    end else if (cmd.year_step) begin
      rem  <= rem - {{(REM_W-9){1'b0}}, ylen};
      yoff <= yoff + 1'b1;
    end else if (cmd.month_step) begin
      rem   <= rem - {{(REM_W-5){1'b0}}, mlen};
      month <= month + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      year_out  <= FIRST_YEAR + {{(12-YOFF_W){1'b0}}, yoff};
      month_out <= month;
      day_out   <= rem[4:0] + 5'd1;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/dntd_ctrl.sv
`default_nettype none

module dntd_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire dntd_pkg::dntd_sts_t sts,
  output dntd_pkg::dntd_cmd_t      cmd
);
  import dntd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_YEARS,
    ST_MONTHS
  } state_t;

  state_t state;
  logic   out_free;
  logic   month_done;

  assign in_ready   = (state == ST_IDLE);
  assign out_free   = !out_valid || out_ready;
  assign month_done = sts.rem_lt_month || sts.month_last;

  // commands to the datapath
  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.load = in_valid;
      end
      ST_YEARS: begin
        cmd.year_step = !sts.rem_lt_year;
      end
      ST_MONTHS: begin
        cmd.month_step = !month_done;
        cmd.capture    = month_done && out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // result valid rises on capture and falls once the item is taken
      if (cmd.capture) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_YEARS;
          end
        end
        ST_YEARS: begin
          if (sts.rem_lt_year) begin
            state <= ST_MONTHS;
          end
        end
        ST_MONTHS: begin
          // wait here while the previous item is still unread
          if (month_done && out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/day_number_to_date.sv
// Converts a signed day number (1 is 1900-01-01) into a Gregorian year, month
// and day. Day numbers below 1 give 1900-01-01 and those above 73049 give
// 2099-12-31. One item is worked at a time: after it is accepted the datapath
// takes away one whole year per cycle and then one whole month per cycle; there
// are 0 to 199 whole years and 0 to 11 whole months before the date. The next
// item can be taken in the same cycle that the result appears. The result sits
// in an output register, so a finished item may wait for the reader while the
// next one is already being converted.
`default_nettype none

`include "day_number_to_date_defines.svh"

module day_number_to_date (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] day_number,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [11:0]             year_out,
  output logic [3:0]              month_out,
  output logic [4:0]              day_out
);
  import dntd_pkg::*;

  dntd_cmd_t cmd;
  dntd_sts_t sts;

  // sequencer
  dntd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // year and month subtraction datapath
  dntd_dpath u_dpath (
    .clk        (clk),
    .day_number (day_number),
    .cmd        (cmd),
    .sts        (sts),
    .year_out   (year_out),
    .month_out  (month_out),
    .day_out    (day_out)
  );

  // checks
  `DNTD_ASSERT_NOW(a_year_range, out_valid, (year_out >= FIRST_YEAR) && (year_out <= 12'd2099))
  `DNTD_ASSERT_NOW(a_month_range, out_valid, (month_out >= MONTH_JAN) && (month_out <= MONTH_DEC))
  `DNTD_ASSERT_NOW(a_day_nonzero, out_valid, day_out != '0)
  `DNTD_ASSERT_NOW(a_feb_len, out_valid && (month_out == MONTH_FEB), day_out <= DAYS_LEAP_FEB)
  `DNTD_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

endmodule

`default_nettype wire

// File: dv/tb_day_number_to_date.sv
`timescale 1ns / 1ps

module tb_day_number_to_date;

  localparam int EPOCH_YEAR   = 1900;
  localparam int LAST_DAY_NUM = 73049;
  localparam int RANDOM_ITEMS = 1900;
  localparam int PAUSE_AT     = 950;
  localparam int TAIL_CYCLES  = 240;
  localparam int CYCLE_LIMIT  = 2_000_000;

  localparam int DAYS_IN_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  typedef struct {
    logic signed [31:0] src;
    date_t              date;
  } pending_date_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] day_number;
  logic               out_valid;
  logic               out_ready;
  logic [11:0]        year_out;
  logic [3:0]         month_out;
  logic [4:0]         day_out;

  int cycle_count;

  // full gregorian rule, not just the 1900..2099 shortcut
  function automatic bit leap_year(input int yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  function automatic int month_days(input int yr, input int mo);
    if (mo == 2 && leap_year(yr)) begin
      return 29;
    end
    return DAYS_IN_MONTH[mo - 1];
  endfunction

  // expected dates in acceptance order
  class date_scoreboard;
    pending_date_t dates_due[$];
    int            err_count;

    function new();
      err_count = 0;
    endfunction

    // walk whole years, then whole months, from the epoch
    function date_t day_to_date(input logic signed [31:0] n);
      date_t       d;
      int unsigned rem;
      int          yr;
      int          mo;
      if (n < 1) begin
        d.year  = 12'(EPOCH_YEAR);
        d.month = 4'd1;
        d.day   = 5'd1;
        return d;
      end
      if (n > LAST_DAY_NUM) begin
        d.year  = 12'(EPOCH_YEAR + 199);
        d.month = 4'd12;
        d.day   = 5'd31;
        return d;
      end
      rem = n - 1;
      yr  = EPOCH_YEAR;
      while (rem >= (leap_year(yr) ? 366 : 365)) begin
        rem -= leap_year(yr) ? 366 : 365;
        yr++;
      end
      mo = 1;
      while (mo < 12 && rem >= month_days(yr, mo)) begin
        rem -= month_days(yr, mo);
        mo++;
      end
      d.year  = 12'(yr);
      d.month = 4'(mo);
      d.day   = 5'(rem + 1);
      return d;
    endfunction

    function void note_day(input logic signed [31:0] n);
      pending_date_t p;
      p.src  = n;
      p.date = day_to_date(n);
      dates_due.push_back(p);
    endfunction

    task report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      err_count++;
    endtask

    task check_date(input logic [11:0] y, input logic [3:0] m, input logic [4:0] d);
      pending_date_t p;
      if (dates_due.size() == 0) begin
        report_mismatch($sformatf("unexpected item %0d-%0d-%0d", y, m, d));
        return;
      end
      p = dates_due.pop_front();
      if (y !== p.date.year) begin
        report_mismatch($sformatf("day %0d year %0d, want %0d", p.src, y, p.date.year));
      end
      if (m !== p.date.month) begin
        report_mismatch($sformatf("day %0d month %0d, want %0d", p.src, m, p.date.month));
      end
      if (d !== p.date.day) begin
        report_mismatch($sformatf("day %0d day %0d, want %0d", p.src, d, p.date.day));
      end
    endtask
  endclass

  date_scoreboard sb;

  day_number_to_date u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .day_number (day_number),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .year_out   (year_out),
    .month_out  (month_out),
    .day_out    (day_out)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // cycle limit
  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) begin
      @(posedge clk);
    end
    $display("status: fail");
    $finish;
  end

  // observe both handshakes at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        sb.note_day(day_number);
      end
      if (out_valid && out_ready) begin
        sb.check_date(year_out, month_out, day_out);
      end
    end
  end

  // receiver stalls: always ready, sparse stalls, or long stall runs
  initial begin
    int mode;
    int mode_left;
    int hold;
    out_ready = 1'b0;
    mode      = 0;
    mode_left = 0;
    hold      = 0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(64, 512);
      end
      mode_left--;
      case (mode)
        0: begin
          out_ready <= 1'b1;
        end
        1: begin
          out_ready <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          if (hold > 0) begin
            hold--;
          end else if (out_ready) begin
            out_ready <= 1'b0;
            hold = $urandom_range(1, 15);
          end else begin
            out_ready <= 1'b1;
            hold = $urandom_range(0, 2);
          end
        end
      endcase
    end
  end

  // present one item and hold it until taken; returns on the next falling edge
  task automatic send_day(input logic signed [31:0] n);
    in_valid   <= 1'b1;
    day_number <= n;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // drop valid and wait for every outstanding date
  task automatic drain_dates();
    in_valid <= 1'b0;
    while (sb.dates_due.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // mostly in-span days, with edges, year starts and full 32-bit noise
  function automatic logic signed [31:0] random_day();
    int unsigned sel;
    int          target;
    int          yr;
    int          n;
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      return $urandom_range(1, LAST_DAY_NUM);
    end else if (sel < 70) begin
      return int'($urandom_range(0, 6)) - 3;
    end else if (sel < 78) begin
      return LAST_DAY_NUM - 3 + int'($urandom_range(0, 6));
    end else if (sel < 90) begin
      // around a new year or the end of february
      target = EPOCH_YEAR + $urandom_range(0, 199);
      n = 1;
      for (yr = EPOCH_YEAR; yr < target; yr++) begin
        n += leap_year(yr) ? 366 : 365;
      end
      n += int'($urandom_range(0, 61)) - 1;
      return n;
    end else if (sel < 95) begin
      return -int'($urandom_range(1, 1000));
    end
    return $urandom;
  endfunction

  // stimulus
  initial begin
    logic signed [31:0] directed_days [$];
    int burst_left;
    int gap;
    int i;
    sb         = new();
    rst        = 1'b1;
    in_valid   = 1'b0;
    day_number = '0;
    directed_days = '{
      32'sh8000_0000, -32'sd1, 32'sd0, 32'sd1, 32'sd2, 32'sd31, 32'sd32, 32'sd59,
      32'sd60, 32'sd61, 32'sd365, 32'sd366, 32'sd1461, 32'sd1520, 32'sd1521,
      32'sd36524, 32'sd36525, 32'sd36584, 32'sd36585, 32'sd36890, 32'sd65536,
      32'sd73048, 32'sd73049, 32'sd73050, 32'sh7fff_ffff
    };
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed items back to back
    foreach (directed_days[k]) begin
      send_day(directed_days[k]);
    end
    drain_dates();

    // random items in bursts
    burst_left = 0;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == PAUSE_AT) begin
        drain_dates();
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid   <= 1'b0;
          day_number <= $urandom;
          repeat (gap) @(negedge clk);
        end
      end
      burst_left--;
      send_day(random_day());
    end
    drain_dates();

    // let any stray item show up
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.err_count == 0 && sb.dates_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
